### sv/plpc_pkg.sv
`default_nettype none
package plpc_pkg;

  // sizing
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int PIXEL_BITS = 16;

  // fixed field widths of the channels
  localparam int PIX_FIELD_W = 16;
  localparam int OUT_ROW_W   = 10;
  localparam int OUT_COL_W   = 10;
  localparam int CLASS_W     = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int SIZE_REG_W  = 11;
  localparam int STEP_W      = 8;

  // derived widths
  localparam int ENT_W   = PIXEL_BITS + 1;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int WCNT_W  = $clog2(MAX_WIDTH + 1);
  localparam int HCNT_W  = $clog2(MAX_HEIGHT + 2);
  localparam int FCNT_W  = $clog2(MAX_WIDTH + 2);
  localparam int POS_W   = ((WCNT_W > HCNT_W) ? WCNT_W : HCNT_W) + 1;
  localparam int STEP_N  = (ROW_W > COL_W) ? ROW_W : COL_W;

  // result queue between front and back
  localparam int QDEPTH  = 8;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_STEP       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_STEP       = 3'd4;

  // reset values of the registers
  localparam logic [SIZE_REG_W-1:0]  RST_IMAGE_WIDTH    = 11'd1024;
  localparam logic [SIZE_REG_W-1:0]  RST_IMAGE_HEIGHT   = 11'd1024;
  localparam logic [PIX_FIELD_W-1:0] RST_PEAK_THRESHOLD = 16'd213;
  localparam logic [STEP_W-1:0]      RST_ROW_STEP       = 8'd1;
  localparam logic [STEP_W-1:0]      RST_COL_STEP       = 8'd1;

  // item opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // class codes
  localparam logic [CLASS_W-1:0] CLS_ALL_LOWER    = 3'd0;
  localparam logic [CLASS_W-1:0] CLS_LOWER_ONLY   = 3'd1;
  localparam logic [CLASS_W-1:0] CLS_MORE_LOWER   = 3'd2;
  localparam logic [CLASS_W-1:0] CLS_BALANCED     = 3'd3;
  localparam logic [CLASS_W-1:0] CLS_GREATER_ONLY = 3'd4;
  localparam logic [CLASS_W-1:0] CLS_MORE_GREATER = 3'd5;

  // effective configuration, already clamped
  typedef struct packed {
    logic [WCNT_W-1:0]      width;
    logic [HCNT_W-1:0]      height;
    logic [PIX_FIELD_W-1:0] threshold;
    logic [STEP_W-1:0]      row_step;
    logic [STEP_W-1:0]      col_step;
  } cfg_t;

  // classified centre waiting for the sampling check
  typedef struct packed {
    logic [ROW_W-1:0]       row;
    logic [COL_W-1:0]       col;
    logic [PIX_FIELD_W-1:0] value;
    logic [CLASS_W-1:0]     code;
    logic                   peak;
  } cand_t;

endpackage
`default_nettype wire

### sv/plpc_if.sv
`default_nettype none

// input item channel
interface plpc_in_if import plpc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   op;
  logic [PIX_FIELD_W-1:0] pixel;
  logic                   mask_on;

  modport source (output valid, op, pixel, mask_on, input ready);
  modport sink   (input valid, op, pixel, mask_on, output ready);
endinterface

// result item channel
interface plpc_out_if import plpc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [OUT_ROW_W-1:0]   out_row;
  logic [OUT_COL_W-1:0]   out_col;
  logic [PIX_FIELD_W-1:0] centre_value;
  logic [CLASS_W-1:0]     class_code;
  logic                   is_peak;

  modport source (output valid, out_row, out_col, centre_value, class_code, is_peak,
                  input ready);
  modport sink   (input valid, out_row, out_col, centre_value, class_code, is_peak,
                  output ready);
endinterface

// register write channel
interface plpc_cfg_if import plpc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### sv/plpc_ram.sv
`default_nettype none
module plpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // one write port, one registered read port, read returns old data on collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

### sv/plpc_front.sv
`default_nettype none
module plpc_front import plpc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cfg_t              cfg,
  plpc_in_if.sink                in_ch,
  input  wire logic [QCNT_W-1:0] q_level,
  output logic                   push_v,
  output cand_t                  push_item
);

  // position counters
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [FCNT_W-1:0] fc_r, fc_nxt;

  // accept stage decode
  logic [POS_W-1:0] r, c, w, h, pr, pc, addr0, cr0, cc0;
  logic             issue0, zero0, we0, ok0, acc;
  logic [ENT_W-1:0] nv0;

  // read stage
  logic             s1_v_r, s1_we_r, s1_zero_r, s1_fwd_r, s1_ok_r;
  logic [COL_W-1:0] s1_addr_r, s1_cc_r;
  logic [ROW_W-1:0] s1_cr_r;
  logic [ENT_W-1:0] s1_nv_r, s1_bot_r, s1_fwd_a_r, s1_fwd_b_r;
  logic [ENT_W-1:0] a_q, b_q, top1, mid1;
  logic             top_ok, bot_ok, left_ok, right_ok;
  logic [8:0]       nbm1;

  // window and classify stage
  logic [ENT_W-1:0] win_r [9];
  logic             s2_v_r;
  logic [8:0]       s2_nbm_r;
  logic [ROW_W-1:0] s2_cr_r;
  logic [COL_W-1:0] s2_cc_r;
  logic [PIXEL_BITS-1:0] val2;
  logic [8:0]       lt2, gt2;
  logic [3:0]       nl2, ng2;
  logic [CLASS_W-1:0] code2;
  logic             peak2;

  // room check: queue level plus items still in the pipe
  logic [QCNT_W:0] load;
  assign load = (QCNT_W + 1)'(q_level) + (QCNT_W + 1)'(s1_v_r) + (QCNT_W + 1)'(s2_v_r);
  assign in_ch.ready = (load < (QCNT_W + 1)'(QDEPTH));
  assign acc = in_ch.valid & in_ch.ready;

  assign nv0 = {in_ch.mask_on, in_ch.pixel[PIXEL_BITS-1:0]};

  // decode the item: store column, centre position, counter updates
  always_comb begin
    r       = POS_W'(row_r);
    c       = POS_W'(col_r);
    w       = POS_W'(cfg.width);
    h       = POS_W'(cfg.height);
    pr      = '0;
    pc      = '0;
    addr0   = '0;
    zero0   = 1'b0;
    we0     = 1'b0;
    issue0  = 1'b0;
    row_nxt = row_r;
    col_nxt = col_r;
    fc_nxt  = fc_r;
    if (in_ch.op == OP_PIXEL) begin
      if (c >= w) begin
        c = '0;
        r = r + 1'b1;
      end
      if (r >= h) begin
        r = '0;
      end
      pr     = r;
      pc     = c;
      addr0  = c;
      we0    = 1'b1;
      issue0 = 1'b1;
      c = c + 1'b1;
      if (c >= w) begin
        c = '0;
        r = r + 1'b1;
        if (r >= h) begin
          r = '0;
        end
      end
      row_nxt = ROW_W'(r);
      col_nxt = COL_W'(c);
      fc_nxt  = '0;
    end else if (row_r == '0 && col_r == '0 && POS_W'(fc_r) <= w) begin
      // flush at a frame boundary: blank row below the image, then one blank column
      issue0 = 1'b1;
      if (POS_W'(fc_r) < w) begin
        pr    = h;
        pc    = POS_W'(fc_r);
        addr0 = POS_W'(fc_r);
      end else begin
        pr    = h + 1'b1;
        pc    = '0;
        zero0 = 1'b1;
      end
      fc_nxt = fc_r + 1'b1;
    end
    // centre lags the input by one row and one column
    if (pc != '0) begin
      ok0 = (pr != '0);
      cr0 = pr - 1'b1;
      cc0 = pc - 1'b1;
    end else begin
      ok0 = (pr >= POS_W'(2));
      cr0 = pr - POS_W'(2);
      cc0 = w - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
      fc_r  <= '0;
    end else if (acc) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      fc_r  <= fc_nxt;
    end
  end

  // line stores: a holds the previous row, b the one before
  plpc_ram #(.WIDTH(ENT_W), .DEPTH(MAX_WIDTH)) u_line_a (
    .clk   (clk),
    .we    (s1_v_r & s1_we_r),
    .waddr (s1_addr_r),
    .wdata (s1_nv_r),
    .re    (acc & issue0 & ~zero0),
    .raddr (COL_W'(addr0)),
    .rdata (a_q)
  );

  plpc_ram #(.WIDTH(ENT_W), .DEPTH(MAX_WIDTH)) u_line_b (
    .clk   (clk),
    .we    (s1_v_r & s1_we_r),
    .waddr (s1_addr_r),
    .wdata (mid1),
    .re    (acc & issue0 & ~zero0),
    .raddr (COL_W'(addr0)),
    .rdata (b_q)
  );

  // column entering the window, with bypass of a write in the same cycle
  assign top1 = s1_zero_r ? '0 : (s1_fwd_r ? s1_fwd_b_r : b_q);
  assign mid1 = s1_zero_r ? '0 : (s1_fwd_r ? s1_fwd_a_r : a_q);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= acc & issue0;
    end
  end

  always_ff @(posedge clk) begin
    s1_we_r    <= we0;
    s1_zero_r  <= zero0;
    s1_addr_r  <= COL_W'(addr0);
    s1_nv_r    <= nv0;
    s1_bot_r   <= we0 ? nv0 : '0;
    s1_fwd_r   <= s1_v_r & s1_we_r & (s1_addr_r == COL_W'(addr0));
    s1_fwd_a_r <= s1_nv_r;
    s1_fwd_b_r <= mid1;
    s1_ok_r    <= ok0;
    s1_cr_r    <= ROW_W'(cr0);
    s1_cc_r    <= COL_W'(cc0);
  end

  // which neighbours lie inside the image
  assign top_ok   = (s1_cr_r != '0);
  assign bot_ok   = (POS_W'(s1_cr_r) + 1'b1 < POS_W'(cfg.height));
  assign left_ok  = (s1_cc_r != '0);
  assign right_ok = (POS_W'(s1_cc_r) + 1'b1 < POS_W'(cfg.width));
  assign nbm1 = {bot_ok & right_ok, bot_ok, bot_ok & left_ok,
                 right_ok, 1'b0, left_ok,
                 top_ok & right_ok, top_ok, top_ok & left_ok};

  // window shift: each row moves left, new column enters on the right
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_v_r) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= top1;
      win_r[3] <= win_r[4];
      win_r[4] <= win_r[5];
      win_r[5] <= mid1;
      win_r[6] <= win_r[7];
      win_r[7] <= win_r[8];
      win_r[8] <= s1_bot_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r & s1_ok_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_nbm_r <= nbm1;
    s2_cr_r  <= s1_cr_r;
    s2_cc_r  <= s1_cc_r;
  end

  // compare centre against the in-image neighbours
  assign val2 = win_r[4][PIXEL_BITS-1:0];

  always_comb begin
    nl2 = '0;
    ng2 = '0;
    for (int i = 0; i < 9; i++) begin
      lt2[i] = s2_nbm_r[i] & (win_r[i][PIXEL_BITS-1:0] < val2);
      gt2[i] = s2_nbm_r[i] & (win_r[i][PIXEL_BITS-1:0] > val2);
      nl2 = nl2 + 4'(lt2[i]);
      ng2 = ng2 + 4'(gt2[i]);
    end
  end

  // first matching class wins
  always_comb begin
    if (nl2 == 4'd8) begin
      code2 = CLS_ALL_LOWER;
    end else if (nl2 != '0 && ng2 == '0) begin
      code2 = CLS_LOWER_ONLY;
    end else if (nl2 > ng2) begin
      code2 = CLS_MORE_LOWER;
    end else if (nl2 == ng2) begin
      code2 = CLS_BALANCED;
    end else if (ng2 != '0 && nl2 == '0) begin
      code2 = CLS_GREATER_ONLY;
    end else begin
      code2 = CLS_MORE_GREATER;
    end
  end

  assign peak2 = ((s2_nbm_r & ~lt2) == '0) &&
                 (PIX_FIELD_W'(val2) >= cfg.threshold);

  // only masked centres go on to the sampling check
  assign push_v          = s2_v_r & win_r[4][PIXEL_BITS];
  assign push_item.row   = s2_cr_r;
  assign push_item.col   = s2_cc_r;
  assign push_item.value = PIX_FIELD_W'(val2);
  assign push_item.code  = code2;
  assign push_item.peak  = peak2;

endmodule
`default_nettype wire

### sv/plpc_fifo.sv
`default_nettype none
module plpc_fifo import plpc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire cand_t             push_item,
  input  wire logic              pop,
  output logic                   head_v,
  output cand_t                  head_item,
  output logic [QCNT_W-1:0]      level
);

  cand_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_pop;

  assign head_v    = (cnt_r != '0);
  assign head_item = mem_r[rp_r];
  assign level     = cnt_r;
  assign do_pop    = pop & head_v;

  // storage, no reset on payload
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == QPTR_W'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == QPTR_W'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(do_pop);
    end
  end

endmodule
`default_nettype wire

### sv/plpc_back.sv
`default_nettype none
module plpc_back import plpc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire logic  head_v,
  input  wire cand_t head_item,
  output logic       pop,
  plpc_out_if.source out_ch
);

  // remainder stages: one dividend bit per stage for row and column
  logic              st_v_r    [STEP_N];
  cand_t             st_item_r [STEP_N];
  logic [STEP_W-1:0] st_rrem_r [STEP_N];
  logic [STEP_W-1:0] st_crem_r [STEP_N];
  logic [STEP_W-1:0] rrem_nxt  [STEP_N];
  logic [STEP_W-1:0] crem_nxt  [STEP_N];
  logic [STEP_N-1:0] rdiv0;
  logic [STEP_N-1:0] cdiv0;
  logic [STEP_N-1:0] rdiv [STEP_N];
  logic [STEP_N-1:0] cdiv [STEP_N];

  logic  out_v_r;
  cand_t out_item_r;
  logic  adv;

  // shift in one bit, subtract the divisor if it fits
  function automatic logic [STEP_W-1:0] rem_step(input logic [STEP_W-1:0] rem,
                                                 input logic b,
                                                 input logic [STEP_W-1:0] d);
    logic [STEP_W:0] t;
    t = {rem, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[STEP_W-1:0];
  endfunction

  // whole chain moves when the output register is free or being taken
  assign adv = ~out_v_r | out_ch.ready;
  assign pop = adv;

  assign rdiv0 = STEP_N'(head_item.row);
  assign cdiv0 = STEP_N'(head_item.col);

  always_comb begin
    for (int k = 0; k < STEP_N; k++) begin
      rdiv[k] = STEP_N'(st_item_r[k].row);
      cdiv[k] = STEP_N'(st_item_r[k].col);
    end
    rrem_nxt[0] = rem_step('0, rdiv0[STEP_N-1], cfg.row_step);
    crem_nxt[0] = rem_step('0, cdiv0[STEP_N-1], cfg.col_step);
    for (int k = 1; k < STEP_N; k++) begin
      rrem_nxt[k] = rem_step(st_rrem_r[k-1], rdiv[k-1][STEP_N-1-k], cfg.row_step);
      crem_nxt[k] = rem_step(st_crem_r[k-1], cdiv[k-1][STEP_N-1-k], cfg.col_step);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < STEP_N; k++) begin
        st_v_r[k] <= 1'b0;
      end
      out_v_r <= 1'b0;
    end else if (adv) begin
      st_v_r[0] <= head_v;
      for (int k = 1; k < STEP_N; k++) begin
        st_v_r[k] <= st_v_r[k-1];
      end
      // keep only centres on a sampled row and column
      out_v_r <= st_v_r[STEP_N-1] && st_rrem_r[STEP_N-1] == '0 &&
                 st_crem_r[STEP_N-1] == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_item_r[0] <= head_item;
      for (int k = 1; k < STEP_N; k++) begin
        st_item_r[k] <= st_item_r[k-1];
      end
      for (int k = 0; k < STEP_N; k++) begin
        st_rrem_r[k] <= rrem_nxt[k];
        st_crem_r[k] <= crem_nxt[k];
      end
      out_item_r <= st_item_r[STEP_N-1];
    end
  end

  // result register drives the channel
  assign out_ch.valid        = out_v_r;
  assign out_ch.out_row      = OUT_ROW_W'(out_item_r.row);
  assign out_ch.out_col      = OUT_COL_W'(out_item_r.col);
  assign out_ch.centre_value = out_item_r.value;
  assign out_ch.class_code   = out_item_r.code;
  assign out_ch.is_peak      = out_item_r.peak;

endmodule
`default_nettype wire

### sv/pixel_local_peak_classifier.sv
`default_nettype none
// Classifies each pixel of a raster stream against its in-image 3x3 neighbours and
// reports masked centres on the sampled rows and columns. The block takes one item
// per clock while input ready is high: the line stores are two single-port-write,
// registered-read RAMs that each pixel item reads and writes once, a same-column
// bypass covers back-to-back items, and the eight compares of the window are
// combinational. A result for the item that completes its window passes accept,
// store read, compare, queue, a 10-stage sampling remainder and the output register.
// An 8-entry queue between the classifier and the sampling stage lets either side
// stall; input ready drops only when that queue could fill. A result for the last
// rows needs flush items (op = 1) after the frame: one per column plus one. The line
// stores are not cleared after reset and the block is ready at once.
module pixel_local_peak_classifier import plpc_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  plpc_cfg_if.sink    cfg_ch,
  plpc_in_if.sink     in_ch,
  plpc_out_if.source  out_ch
);

  logic [SIZE_REG_W-1:0]  width_r;
  logic [SIZE_REG_W-1:0]  height_r;
  logic [PIX_FIELD_W-1:0] thresh_r;
  logic [STEP_W-1:0]      rstep_r;
  logic [STEP_W-1:0]      cstep_r;
  cfg_t                   cfg;

  logic              push_v;
  cand_t             push_item;
  logic              head_v;
  cand_t             head_item;
  logic              pop;
  logic [QCNT_W-1:0] q_level;

  assign cfg_ch.ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_IMAGE_WIDTH;
      height_r <= RST_IMAGE_HEIGHT;
      thresh_r <= RST_PEAK_THRESHOLD;
      rstep_r  <= RST_ROW_STEP;
      cstep_r  <= RST_COL_STEP;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_IMAGE_WIDTH:    width_r  <= cfg_ch.data[SIZE_REG_W-1:0];
        CFG_IMAGE_HEIGHT:   height_r <= cfg_ch.data[SIZE_REG_W-1:0];
        CFG_PEAK_THRESHOLD: thresh_r <= cfg_ch.data[PIX_FIELD_W-1:0];
        CFG_ROW_STEP:       rstep_r  <= cfg_ch.data[STEP_W-1:0];
        CFG_COL_STEP:       cstep_r  <= cfg_ch.data[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // clamp sizes and steps to their working ranges
  always_comb begin
    if (width_r == '0) begin
      cfg.width = WCNT_W'(1);
    end else if (int'(width_r) > MAX_WIDTH) begin
      cfg.width = WCNT_W'(MAX_WIDTH);
    end else begin
      cfg.width = WCNT_W'(width_r);
    end
    if (height_r == '0) begin
      cfg.height = HCNT_W'(1);
    end else if (int'(height_r) > MAX_HEIGHT) begin
      cfg.height = HCNT_W'(MAX_HEIGHT);
    end else begin
      cfg.height = HCNT_W'(height_r);
    end
    cfg.threshold = thresh_r;
    cfg.row_step  = (rstep_r == '0) ? STEP_W'(1) : rstep_r;
    cfg.col_step  = (cstep_r == '0) ? STEP_W'(1) : cstep_r;
  end

  plpc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .q_level   (q_level),
    .push_v    (push_v),
    .push_item (push_item)
  );

  plpc_fifo u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_v),
    .push_item (push_item),
    .pop       (pop),
    .head_v    (head_v),
    .head_item (head_item),
    .level     (q_level)
  );

  plpc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .head_v    (head_v),
    .head_item (head_item),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import plpc_pkg::*;

  localparam int TAIL_CYCLES    = 24;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 850;
  localparam int WIDE_LINE      = 64;

  // one classified centre as it should leave the block
  typedef struct packed {
    logic [OUT_ROW_W-1:0]   row;
    logic [OUT_COL_W-1:0]   col;
    logic [PIX_FIELD_W-1:0] value;
    logic [CLASS_W-1:0]     code;
    logic                   peak;
  } peak_report_t;

  logic clk = 1'b0;
  logic rst_n;

  plpc_cfg_if cfg_ch();
  plpc_in_if  in_ch();
  plpc_out_if out_ch();

  pixel_local_peak_classifier u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shared run state
  bit  calm;
  bit  hold_req;
  int  fails;
  int  items_taken;
  int  reports_seen;
  int  frames_sent;
  int  quiet_cycles;

  // predictor state: registers, line stores, window and raster position
  logic [SIZE_REG_W-1:0]  reg_width;
  logic [SIZE_REG_W-1:0]  reg_height;
  logic [PIX_FIELD_W-1:0] reg_thresh;
  logic [STEP_W-1:0]      reg_rstep;
  logic [STEP_W-1:0]      reg_cstep;
  bit [ENT_W-1:0]         upper_line [MAX_WIDTH];
  bit [ENT_W-1:0]         lower_line [MAX_WIDTH];
  bit [ENT_W-1:0]         win [9];
  int                     pos_row;
  int                     pos_col;
  int                     drain_count;
  peak_report_t           pending_reports [$];

  function automatic int clamp_dim(logic [SIZE_REG_W-1:0] v, int lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : int'(v);
  endfunction

  // shift the window left, new column enters on the right
  function automatic void slide_window(bit [ENT_W-1:0] t, bit [ENT_W-1:0] m,
                                       bit [ENT_W-1:0] b);
    int i;
    for (i = 0; i < 3; i++) begin
      win[i*3]     = win[i*3 + 1];
      win[i*3 + 1] = win[i*3 + 2];
    end
    win[2] = t;
    win[5] = m;
    win[8] = b;
  endfunction

  // classify the window centre for raster position (r,c)
  function automatic void grade_centre(int r, int c, int w, int h);
    int cr, cc, nr, nc, n_lo, n_hi, rs, cs, i;
    bit [PIX_FIELD_W-1:0] v, nv;
    bit peak;
    peak_report_t rep;
    rs = (reg_rstep == 0) ? 1 : int'(reg_rstep);
    cs = (reg_cstep == 0) ? 1 : int'(reg_cstep);
    if (c >= 1) begin
      if (r < 1) return;
      cr = r - 1;
      cc = c - 1;
    end else begin
      if (r < 2) return;
      cr = r - 2;
      cc = w - 1;
    end
    if (!win[4][PIXEL_BITS]) return;
    if ((cr % rs) != 0 || (cc % cs) != 0) return;
    v = win[4][PIXEL_BITS-1:0];
    n_lo = 0;
    n_hi = 0;
    peak = 1'b1;
    // neighbours off the image are skipped
    for (i = 0; i < 9; i++) begin
      nr = cr + i / 3 - 1;
      nc = cc + i % 3 - 1;
      if (i != 4 && nr >= 0 && nc >= 0 && nr < h && nc < w) begin
        nv = win[i][PIXEL_BITS-1:0];
        if (nv > v) n_hi++;
        else if (nv < v) n_lo++;
        if (nv >= v) peak = 1'b0;
      end
    end
    if (n_lo == 8) rep.code = CLS_ALL_LOWER;
    else if (n_lo > 0 && n_hi == 0) rep.code = CLS_LOWER_ONLY;
    else if (n_lo > n_hi) rep.code = CLS_MORE_LOWER;
    else if (n_lo == n_hi) rep.code = CLS_BALANCED;
    else if (n_hi > 0 && n_lo == 0) rep.code = CLS_GREATER_ONLY;
    else rep.code = CLS_MORE_GREATER;
    rep.row   = cr[OUT_ROW_W-1:0];
    rep.col   = cc[OUT_COL_W-1:0];
    rep.value = v;
    rep.peak  = peak && (v >= reg_thresh);
    pending_reports = {pending_reports, rep};
  endfunction

  // advance the predictor by one accepted item
  function automatic void take_item(logic op, logic [PIX_FIELD_W-1:0] pix, logic m);
    int w, h, r, c;
    bit [ENT_W-1:0] above, prev, ent;
    w = clamp_dim(reg_width, MAX_WIDTH);
    h = clamp_dim(reg_height, MAX_HEIGHT);
    if (op == OP_PIXEL) begin
      r = pos_row;
      c = pos_col;
      drain_count = 0;
      if (c >= w) begin
        c = 0;
        r++;
      end
      if (r >= h) r = 0;
      ent = {m, pix};
      above = upper_line[c];
      prev  = lower_line[c];
      upper_line[c] = prev;
      lower_line[c] = ent;
      slide_window(above, prev, ent);
      grade_centre(r, c, w, h);
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
      pos_row = r;
      pos_col = c;
    end else if (pos_row == 0 && pos_col == 0 && drain_count <= w) begin
      // flush drains the last rows, only at a frame boundary
      if (drain_count < w) begin
        slide_window(upper_line[drain_count], lower_line[drain_count], '0);
        grade_centre(h, drain_count, w, h);
      end else begin
        slide_window('0, '0, '0);
        grade_centre(h + 1, 0, w, h);
      end
      drain_count++;
    end
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_IMAGE_WIDTH:    reg_width  = d[SIZE_REG_W-1:0];
      CFG_IMAGE_HEIGHT:   reg_height = d[SIZE_REG_W-1:0];
      CFG_PEAK_THRESHOLD: reg_thresh = d[PIX_FIELD_W-1:0];
      CFG_ROW_STEP:       reg_rstep  = d[STEP_W-1:0];
      CFG_COL_STEP:       reg_cstep  = d[STEP_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  // predict on accepted items and registers, check accepted results
  always @(posedge clk) begin : scoreboard
    peak_report_t want;
    int i;
    if (!rst_n) begin
      reg_width   = RST_IMAGE_WIDTH;
      reg_height  = RST_IMAGE_HEIGHT;
      reg_thresh  = RST_PEAK_THRESHOLD;
      reg_rstep   = RST_ROW_STEP;
      reg_cstep   = RST_COL_STEP;
      pos_row     = 0;
      pos_col     = 0;
      drain_count = 0;
      for (i = 0; i < 9; i++) win[i] = '0;
      pending_reports.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) apply_reg(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready) begin
        take_item(in_ch.op, in_ch.pixel, in_ch.mask_on);
        items_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        reports_seen++;
        if (pending_reports.size() == 0) begin
          $error("result with none expected: row %0d col %0d", out_ch.out_row,
                 out_ch.out_col);
          fails++;
        end else begin
          want = pending_reports.pop_front();
          check_field("out_row", 32'(want.row), 32'(out_ch.out_row));
          check_field("out_col", 32'(want.col), 32'(out_ch.out_col));
          check_field("centre_value", 32'(want.value), 32'(out_ch.centre_value));
          check_field("class_code", 32'(want.code), 32'(out_ch.class_code));
          check_field("is_peak", 32'(want.peak), 32'(out_ch.is_peak));
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(12, 48);
    return $urandom_range(1, 3);
  endfunction

  // result sink: random stalls, plus one long hold when asked
  initial begin : result_sink
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // values that give ties, near-threshold peaks and extremes
  function automatic logic [PIX_FIELD_W-1:0] pick_pixel();
    case ($urandom_range(0, 3))
      0:       return PIX_FIELD_W'($urandom_range(0, 3));
      1:       return PIX_FIELD_W'(65535 - $urandom_range(0, 3));
      2:       return PIX_FIELD_W'($urandom_range(200, 230));
      default: return PIX_FIELD_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // offer one item, return at the edge that accepts it; valid stays high
  task automatic send_item(logic op, logic [PIX_FIELD_W-1:0] pix, logic m);
    int gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.op      <= op;
    in_ch.pixel   <= pix;
    in_ch.mask_on <= m;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain(int n);
    int i;
    for (i = 0; i < n; i++)
      send_item(OP_FLUSH, PIX_FIELD_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
  endtask

  // wait for every expected result, then let the pipeline go quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // write all five registers back to back once the block is idle
  task automatic program_regs(int w, int h, int thr, int rs, int cs);
    logic [CFG_IDX_W-1:0]  regs [5];
    logic [CFG_DATA_W-1:0] vals [5];
    int i;
    settle();
    regs[0] = CFG_IMAGE_WIDTH;    vals[0] = CFG_DATA_W'(w);
    regs[1] = CFG_IMAGE_HEIGHT;   vals[1] = CFG_DATA_W'(h);
    regs[2] = CFG_PEAK_THRESHOLD; vals[2] = CFG_DATA_W'(thr);
    regs[3] = CFG_ROW_STEP;       vals[3] = CFG_DATA_W'(rs);
    regs[4] = CFG_COL_STEP;       vals[4] = CFG_DATA_W'(cs);
    for (i = 0; i < 5; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= regs[i];
      cfg_ch.data  <= vals[i];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // one frame of pixels, optional stray flushes inside, then the drain
  task automatic stream_frame(int w, int h, int mask_pct, int extra, int stray_pct);
    int i;
    for (i = 0; i < w * h; i++) begin
      if ($urandom_range(0, 99) < stray_pct)
        send_item(OP_FLUSH, PIX_FIELD_W'($urandom_range(0, 65535)), 1'b1);
      send_item(OP_PIXEL, pick_pixel(), $urandom_range(0, 99) < mask_pct);
    end
    drain(w + 1 + extra);
    frames_sent++;
  endtask

  // widest line of the run first, so both line stores hold real data in every used column
  task automatic test_widest_line();
    program_regs(WIDE_LINE, 2, 0, 1, 1);
    stream_frame(WIDE_LINE, 2, 50, 1, 0);
  endtask

  // hand-built 4x3 frame: four class shapes, a mid-frame flush, a masked-off edge pixel
  task automatic test_directed_frame();
    int r, c;
    logic [PIX_FIELD_W-1:0] v;
    program_regs(4, 3, int'(RST_PEAK_THRESHOLD), 1, 1);
    for (r = 0; r < 3; r++) begin
      for (c = 0; c < 4; c++) begin
        if (c == 3) v = 16'd5;
        else if (r == 1 && c == 1) v = 16'hFFFF;
        else if ((r + c) % 2 == 1) v = 16'h8000;
        else v = 16'h0000;
        send_item(OP_PIXEL, v, !(r == 2 && c == 2));
        if (r == 1 && c == 1) send_item(OP_FLUSH, 16'hFFFF, 1'b1);
      end
    end
    drain(6);
    frames_sent++;
  endtask

  // zero sizes and steps act as one; partial drain followed by a new pixel
  task automatic test_size_clamp();
    program_regs(0, 0, 65535, 0, 0);
    send_item(OP_PIXEL, 16'hFFFF, 1'b1);
    drain(2);
    send_item(OP_PIXEL, 16'h0000, 1'b1);
    drain(1);
    send_item(OP_PIXEL, 16'hFFFE, 1'b1);
    drain(3);
    frames_sent += 3;
  endtask

  // oversize height, then shrink width and height while the counters are mid-frame
  task automatic test_reshape();
    int i;
    program_regs(5, 2047, int'(RST_PEAK_THRESHOLD), 1, 1);
    for (i = 0; i < 13; i++) send_item(OP_PIXEL, pick_pixel(), 1'b1);
    program_regs(3, 4, int'(RST_PEAK_THRESHOLD), 1, 1);
    for (i = 0; i < 3; i++) send_item(OP_PIXEL, pick_pixel(), 1'b1);
    stream_frame(3, 4, 100, 0, 0);
  endtask

  // long output hold while the input keeps offering a dense frame
  task automatic test_output_hold();
    program_regs(16, 8, 0, 1, 1);
    calm = 1'b1;
    hold_req = 1'b1;
    stream_frame(16, 8, 100, 0, 0);
    calm = 1'b0;
  endtask

  function automatic int pick_step();
    case ($urandom_range(0, 7))
      0:       return 255;
      1:       return 0;
      2, 3:    return $urandom_range(2, 4);
      default: return 1;
    endcase
  endfunction

  function automatic int pick_threshold();
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return 65535;
      2:       return int'(RST_PEAK_THRESHOLD);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // random frames, mostly complete, some abandoned or under-drained
  task automatic test_random_frames();
    int budget, w, h, mask_pct, cut, i;
    budget = 0;
    while (budget < RANDOM_ITEMS) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(20, WIDE_LINE) : $urandom_range(1, 10);
      h = $urandom_range(1, 8);
      program_regs(w, h, pick_threshold(), pick_step(), pick_step());
      calm = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 2))
        0:       mask_pct = 100;
        1:       mask_pct = $urandom_range(0, 30);
        default: mask_pct = $urandom_range(50, 100);
      endcase
      case ($urandom_range(0, 9))
        0: begin
          // abandoned frame with a stray flush
          cut = $urandom_range(1, w * h);
          for (i = 0; i < cut; i++) begin
            send_item(OP_PIXEL, pick_pixel(), $urandom_range(0, 99) < mask_pct);
            if (i == cut / 2) send_item(OP_FLUSH, pick_pixel(), 1'b1);
          end
          budget += cut;
        end
        1: begin
          // complete frame, drain cut short
          cut = $urandom_range(0, w);
          for (i = 0; i < w * h; i++)
            send_item(OP_PIXEL, pick_pixel(), $urandom_range(0, 99) < mask_pct);
          drain(cut);
          budget += w * h + cut;
        end
        default: begin
          stream_frame(w, h, mask_pct, $urandom_range(0, 2),
                       ($urandom_range(0, 3) == 0) ? 5 : 0);
          budget += w * h + w + 1;
        end
      endcase
      frames_sent++;
    end
    calm = 1'b0;
  endtask

  initial begin : main
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.op       = OP_PIXEL;
    in_ch.pixel    = '0;
    in_ch.mask_on  = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = CFG_IMAGE_WIDTH;
    cfg_ch.data    = '0;
    calm           = 1'b0;
    hold_req       = 1'b0;
    quiet_cycles   = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_widest_line();
    test_directed_frame();
    test_size_clamp();
    test_reshape();
    test_output_hold();
    test_random_frames();
    settle();

    $display("run: %0d items over %0d frames, %0d results checked", items_taken,
             frames_sent, reports_seen);
    $display("run: widest line, size and step clamps, reshaped counters, long output hold");
    if (fails == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
sv/plpc_pkg.sv
sv/plpc_if.sv
sv/plpc_ram.sv
sv/plpc_front.sv
sv/plpc_fifo.sv
sv/plpc_back.sv
sv/pixel_local_peak_classifier.sv
test/testbench.sv
